[hdl/hre_pkg.sv]
// Shared constants and types for the harmonic restraint energy/force block.
// No dependencies; imported by hdl/harmonic_restraint_energy_force.sv.
package hre_pkg;

  localparam int FRAC_BITS = 16;

  // Register word indices on paddr[3:2] (byte address is 4*index).
  localparam logic [1:0] REG_BOX_X  = 2'd0;
  localparam logic [1:0] REG_BOX_Y  = 2'd1;
  localparam logic [1:0] REG_BOX_Z  = 2'd2;
  localparam logic [1:0] REG_ZONLY  = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQ     = 8'b0000_0010,
    ST_ROOT   = 8'b0000_0100,
    ST_SPRING = 8'b0000_1000,
    ST_ENERGY = 8'b0001_0000,
    ST_PROJ   = 8'b0010_0000,
    ST_VIR    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } hre_state_e;

endpackage

[hdl/harmonic_restraint_energy_force.sv]
// Harmonic distance restraint with minimum-image folding: force, energy, virial.
// Depends on hdl/hre_pkg.sv.
//
// Usage
//   Input channel (in_valid_i / in_stall_o): one restraint per request. cmd
//   picks a tether (0) or a pair (1). The request is taken when valid is high
//   and stall is low. Output channel (out_valid_o / out_stall_i): one result
//   per request: force on atom b, running energy sum, six running virial sums
//   and batch_done. Running sums clear after the result of a request marked
//   last_item.
//   Sequence: one shared 33x33 multiplier and the serial units work in turn
//   through squaring, the square root, spring and energy, three projections
//   (each a 32-step division), the virial sums and the output step;
//   fifteen multiplier passes in all. A new request is not taken until the
//   result of the last one has been loaded, so requests do not overlap.
//   in_stall_o stays high from acceptance until the result is moved
//   into the output register.
//   Stall: a finished result waits in the output register; the next request
//   is accepted once that result is loaded, and its result in turn holds in
//   the sequencer until the output register frees up.
//   Reset: rst_ni (async, active low) clears box lengths, mode bit, running
//   sums and all handshake state. No clearing pass is needed.
//   Config: APB write at 4*index, pready tied high; write only while idle.
module harmonic_restraint_energy_force (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic signed [31:0] point_a_x_i,
  input  logic signed [31:0] point_a_y_i,
  input  logic signed [31:0] point_a_z_i,
  input  logic signed [31:0] point_b_x_i,
  input  logic signed [31:0] point_b_y_i,
  input  logic signed [31:0] point_b_z_i,
  input  logic [31:0] spring_k_i,
  input  logic [31:0] rest_length_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [63:0] energy_total_o,
  output logic signed [63:0] vir_xx_o,
  output logic signed [63:0] vir_yx_o,
  output logic signed [63:0] vir_yy_o,
  output logic signed [63:0] vir_zx_o,
  output logic signed [63:0] vir_zy_o,
  output logic signed [63:0] vir_zz_o,
  output logic        batch_done_o
);
  import hre_pkg::*;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // ---------------------------------------------------------------- helpers
  // Fold once by the minimum-image rule, then clamp to 32 bits.
  function automatic logic signed [31:0] fold(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [30:0] len);
    logic signed [33:0] d;
    logic signed [33:0] l;
    logic signed [33:0] h;
    d = 34'(b) - 34'(a);
    l = $signed({3'b000, len});
    h = l >>> 1;
    if (d > h) d = d - l;
    else if (d < -h) d = d + l;
    if (d > 34'sh0_7FFF_FFFF) d = 34'sh0_7FFF_FFFF;
    if (d < -34'sh0_8000_0000) d = -34'sh0_8000_0000;
    return d[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [30:0] box_x_q, box_y_q, box_z_q;
  logic        zonly_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= '0;
      box_y_q <= '0;
      box_z_q <= '0;
      zonly_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BOX_X: box_x_q <= pwdata[30:0];
        REG_BOX_Y: box_y_q <= pwdata[30:0];
        REG_BOX_Z: box_z_q <= pwdata[30:0];
        REG_ZONLY: zonly_q <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BOX_X: prdata = {1'b0, box_x_q};
      REG_BOX_Y: prdata = {1'b0, box_y_q};
      REG_BOX_Z: prdata = {1'b0, box_z_q};
      REG_ZONLY: prdata = {31'd0, zonly_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  hre_state_e state_q;
  logic [5:0] cnt_q;
  logic [1:0] comp_q;

  logic signed [31:0] dx_q, dy_q, dz_q;
  logic        umb_q, last_q;
  logic [31:0] k_q, req_q;
  logic [97:0] acc_q;
  logic [63:0] sv_q, res_q, bit_q;
  logic [32:0] r_q, adr_q;
  logic        dr_pos_q, dr_zero_q;
  logic [63:0] prod_q;
  logic [30:0] fmag_q;
  logic [33:0] rem_q;
  logic [31:0] lo_q;
  logic signed [31:0] fx_q, fy_q, fz_q;
  logic signed [63:0] energy_acc_q;
  logic signed [63:0] vir_q [6];
  logic [65:0] mul_q;

  logic        in_acc;
  logic        out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // ---------------------------------------------------------------- shared multiplier
  logic [32:0] mul_a, mul_b;
  logic signed [31:0] d_c;
  logic [2:0]  vj;
  logic signed [31:0] vf, vd;

  // Current projection component displacement.
  always_comb begin
    unique case (comp_q)
      2'd0:    d_c = dx_q;
      2'd1:    d_c = dy_q;
      default: d_c = dz_q;
    endcase
  end

  // Virial pair selection: issue pair cnt, accumulate pair cnt-1.
  function automatic logic signed [31:0] vsel_f(input logic [2:0] j,
      input logic signed [31:0] fx, input logic signed [31:0] fy,
      input logic signed [31:0] fz);
    unique case (j)
      3'd0:       return fx;
      3'd1, 3'd2: return fy;
      default:    return fz;
    endcase
  endfunction

  function automatic logic signed [31:0] vsel_d(input logic [2:0] j,
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z);
    unique case (j)
      3'd0, 3'd1, 3'd3: return x;
      3'd2, 3'd4:       return y;
      default:          return z;
    endcase
  endfunction

  assign vj = cnt_q[2:0] - 3'd1;
  assign vf = vsel_f(vj, fx_q, fy_q, fz_q);
  assign vd = vsel_d(vj, dx_q, dy_q, dz_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        unique case (cnt_q[1:0])
          2'd0:    begin mul_a = {1'b0, mag32(dx_q)}; end
          2'd1:    begin mul_a = {1'b0, mag32(dy_q)}; end
          2'd2:    begin mul_a = {1'b0, mag32(dz_q)}; end
          default: begin mul_a = '0; end
        endcase
        mul_b = mul_a;
      end
      ST_SPRING: begin
        mul_a = {1'b0, k_q};
        mul_b = adr_q;
      end
      ST_ENERGY: begin
        mul_a = cnt_q[0] ? {1'b0, prod_q[63:32]} : {1'b0, prod_q[31:0]};
        mul_b = adr_q;
      end
      ST_PROJ: begin
        mul_a = {2'b00, fmag_q};
        mul_b = {1'b0, mag32(d_c)};
      end
      ST_VIR: begin
        mul_a = {1'b0, mag32(vsel_f(cnt_q[2:0], fx_q, fy_q, fz_q))};
        mul_b = {1'b0, mag32(vsel_d(cnt_q[2:0], dx_q, dy_q, dz_q))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- serial units
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [33:0] rem2;
  logic        dv_ge;
  logic [32:0] r_fin;
  logic [63:0] fsh;
  logic [97:0] acc_e;
  logic signed [63:0] e_val;
  logic signed [31:0] q_s;
  logic        f_zero;
  logic signed [63:0] vprod;

  assign sq_t  = res_q | bit_q;
  assign sq_ge = sv_q >= sq_t;
  assign rem2  = {rem_q[32:0], lo_q[31]};
  assign dv_ge = rem2 >= {1'b0, r_q};
  assign r_fin = umb_q ? {1'b0, mag32(dz_q)} : res_q[32:0];
  assign fsh   = prod_q >> (FRAC_BITS - 1);
  assign acc_e = acc_q >> FRAC_BITS;
  assign e_val = (|acc_q[97:63+FRAC_BITS]) ? S64_MAX : {1'b0, acc_e[62:0]};
  assign q_s   = {1'b0, lo_q[30:0]};
  // Zero force for r = 0, dr = 0, d = 0, or x/y of an umbrella tether.
  assign f_zero = (r_q == '0) || dr_zero_q || (d_c == '0) || (umb_q && comp_q != 2'd2);
  assign vprod  = (vf[31] ^ vd[31]) ? -$signed(mul_q[63:0]) : $signed(mul_q[63:0]);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q   <= fold(point_a_x_i, point_b_x_i, box_x_q);
      dy_q   <= fold(point_a_y_i, point_b_y_i, box_y_q);
      dz_q   <= fold(point_a_z_i, point_b_z_i, box_z_q);
      umb_q  <= !cmd_i && zonly_q;
      last_q <= last_item_i;
      k_q    <= spring_k_i;
      req_q  <= rest_length_i;
      acc_q  <= '0;
    end
    unique case (state_q)
      ST_SQ: begin
        if (cnt_q != 6'd0) acc_q <= acc_q + 98'(mul_q);
        sv_q  <= acc_q[63:0] + ((cnt_q != 6'd0) ? mul_q[63:0] : 64'd0);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      ST_ROOT: begin
        sv_q  <= sq_ge ? sv_q - sq_t : sv_q;
        res_q <= sq_ge ? ((res_q >> 1) | bit_q) : (res_q >> 1);
        bit_q <= bit_q >> 2;
        r_q   <= r_fin;
      end
      ST_SPRING: begin
        if (cnt_q == 6'd0) begin
          // Hold stretch magnitude and sign.
          if (r_q > {1'b0, req_q}) adr_q <= r_q - {1'b0, req_q};
          else                     adr_q <= {1'b0, req_q} - r_q;
          dr_pos_q  <= r_q > {1'b0, req_q};
          dr_zero_q <= r_q == {1'b0, req_q};
        end
        if (cnt_q == 6'd2) prod_q <= mul_q[63:0];
        if (cnt_q == 6'd3) fmag_q <= (|fsh[63:31]) ? {31{1'b1}} : fsh[30:0];
      end
      ST_ENERGY: begin
        if (cnt_q == 6'd1) acc_q <= 98'(mul_q);
        if (cnt_q == 6'd2) acc_q <= acc_q + (98'(mul_q) << 32);
      end
      ST_PROJ: begin
        if (cnt_q == 6'd1) begin
          rem_q <= {2'b00, mul_q[63:32]};
          lo_q  <= mul_q[31:0];
        end else if (cnt_q <= 6'd33) begin
          rem_q <= dv_ge ? rem2 - {1'b0, r_q} : rem2;
          lo_q  <= {lo_q[30:0], dv_ge};
        end else begin
          unique case (comp_q)
            2'd0:    fx_q <= f_zero ? '0 : ((dr_pos_q == !d_c[31]) ? -q_s : q_s);
            2'd1:    fy_q <= f_zero ? '0 : ((dr_pos_q == !d_c[31]) ? -q_s : q_s);
            default: fz_q <= f_zero ? '0 : ((dr_pos_q == !d_c[31]) ? -q_s : q_s);
          endcase
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      comp_q       <= '0;
      energy_acc_q <= '0;
      for (int i = 0; i < 6; i++) vir_q[i] <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      // Load a finished result, else drop the valid once it is taken.
      if (state_q == ST_OUT && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i)             out_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc) state_q <= ST_SQ;
        end
        ST_SQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            cnt_q   <= '0;
            state_q <= ST_SPRING;
          end
        end
        ST_SPRING: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            cnt_q   <= '0;
            state_q <= ST_ENERGY;
          end
        end
        ST_ENERGY: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            energy_acc_q <= sat_add(energy_acc_q, e_val);
            cnt_q        <= '0;
            comp_q       <= '0;
            state_q      <= ST_PROJ;
          end
        end
        ST_PROJ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd34) begin
            cnt_q <= '0;
            if (comp_q == 2'd2) state_q <= ST_VIR;
            else                comp_q  <= comp_q + 2'd1;
          end
        end
        ST_VIR: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q != 6'd0) vir_q[vj] <= sat_add(vir_q[vj], vprod);
          if (cnt_q == 6'd6) begin
            cnt_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold until the output register frees, then drop sums after last.
          if (out_free) begin
            state_q     <= ST_IDLE;
            if (last_q) begin
              energy_acc_q <= '0;
              for (int i = 0; i < 6; i++) vir_q[i] <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      force_x_o      <= fx_q;
      force_y_o      <= fy_q;
      force_z_o      <= fz_q;
      energy_total_o <= energy_acc_q;
      vir_xx_o       <= vir_q[0];
      vir_yx_o       <= vir_q[1];
      vir_yy_o       <= vir_q[2];
      vir_zx_o       <= vir_q[3];
      vir_zy_o       <= vir_q[4];
      vir_zz_o       <= vir_q[5];
      batch_done_o   <= last_q;
    end
  end

endmodule
